[rtl/klgs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package klgs_pkg;

  // Field widths.
  localparam int unsigned CountW = 40;
  localparam int unsigned LastW  = 32;
  localparam int unsigned BxW    = 13;
  localparam int unsigned ByW    = 8;
  localparam int unsigned OutcW  = 3;

  // Serial divider: left-aligned dividend, divisor wide enough for
  // threads per block times y threads (at most 127 * 128 or 8191).
  localparam int unsigned DivDW    = 40;
  localparam int unsigned DivSW    = 14;
  localparam int unsigned DivStepW = 6;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] REG_BLOCK_LIMIT = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_WARP_WIDTH  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CORE_TOTAL  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CORE_LIMIT  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_GRID_LIMIT  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_UNROLL      = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_ROW_MODE    = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_WAVES_MODE  = 3'd7;

  // Outcome codes.
  localparam logic [OutcW-1:0] OC_OK       = 3'd0;
  localparam logic [OutcW-1:0] OC_TRIVIAL  = 3'd1;
  localparam logic [OutcW-1:0] OC_UNROLL   = 3'd2;
  localparam logic [OutcW-1:0] OC_TOO_MANY = 3'd3;
  localparam logic [OutcW-1:0] OC_ZERO_BLK = 3'd4;

  // Sizing constants.
  localparam logic [7:0]     Y_TARGET  = 8'd128;
  localparam logic [BxW-1:0] BX_MAX    = 13'd8191;
  localparam logic [BxW-1:0] WARP_DFLT = 13'd32;

  typedef struct packed {
    logic [12:0] block_thread_limit;
    logic [6:0]  warp_width;
    logic [10:0] core_total;
    logic [12:0] core_thread_limit;
    logic [30:0] grid_x_limit;
    logic [4:0]  unroll;
    logic        row_vector_mode;
    logic        few_waves_mode;
  } klgs_cfg_t;

  typedef struct packed {
    logic                go;
    logic [DivStepW-1:0] steps;
    logic [DivDW-1:0]    dividend;
    logic [DivSW-1:0]    divisor;
  } klgs_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DivDW-1:0] quo;
    logic [DivSW-1:0] rem;
  } klgs_div_rsp_t;

endpackage

`default_nettype wire

[rtl/klgs_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module klgs_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [klgs_pkg::CfgIdxW-1:0]  wr_index,
  input  wire logic [klgs_pkg::CfgDataW-1:0] wr_data,
  output klgs_pkg::klgs_cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_thread_limit <= 13'd1024;
      cfg.warp_width         <= 7'd32;
      cfg.core_total         <= 11'd80;
      cfg.core_thread_limit  <= 13'd2048;
      cfg.grid_x_limit       <= 31'h7FFF_FFFF;
      cfg.unroll             <= 5'd1;
      cfg.row_vector_mode    <= 1'b0;
      cfg.few_waves_mode     <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        klgs_pkg::REG_BLOCK_LIMIT: cfg.block_thread_limit <= wr_data[12:0];
        klgs_pkg::REG_WARP_WIDTH:  cfg.warp_width         <= wr_data[6:0];
        klgs_pkg::REG_CORE_TOTAL:  cfg.core_total         <= wr_data[10:0];
        klgs_pkg::REG_CORE_LIMIT:  cfg.core_thread_limit  <= wr_data[12:0];
        klgs_pkg::REG_GRID_LIMIT:  cfg.grid_x_limit       <= wr_data[30:0];
        klgs_pkg::REG_UNROLL:      cfg.unroll             <= wr_data[4:0];
        klgs_pkg::REG_ROW_MODE:    cfg.row_vector_mode    <= wr_data[0];
        klgs_pkg::REG_WAVES_MODE:  cfg.few_waves_mode     <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/klgs_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle. The dividend arrives
// left-aligned with zero padding below, so after the given number of
// steps the shift register holds exactly the quotient.
module klgs_div (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire klgs_pkg::klgs_div_req_t req,
  output      klgs_pkg::klgs_div_rsp_t rsp
);

  localparam int unsigned DW = klgs_pkg::DivDW;
  localparam int unsigned SW = klgs_pkg::DivSW;

  logic                          active;
  logic                          done;
  logic [klgs_pkg::DivStepW-1:0] cnt;
  logic [DW-1:0]                 dq;
  logic [SW-1:0]                 rem;
  logic [SW-1:0]                 dv;
  logic [SW:0]                   trial;
  logic                          fits;

  assign trial = {rem, dq[DW-1]};
  assign fits  = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        active <= 1'b1;
        cnt    <= req.steps;
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == klgs_pkg::DivStepW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      dq  <= req.dividend;
      rem <= '0;
      dv  <= req.divisor;
    end else if (active) begin
      dq  <= {dq[DW-2:0], fits};
      rem <= fits ? SW'(trial - {1'b0, dv}) : trial[SW-1:0];
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = dq;
  assign rsp.rem  = rem;

endmodule

`default_nettype wire

[rtl/kernel_launch_grid_sizer_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Launch grid sizer. A word is taken when start is high and busy is low.
// The result word is on grid_blocks, block_x, block_y and outcome for
// exactly one cycle, marked by done, and the receiver cannot stall it, so
// it must be captured in that cycle. The ports hold their value until the
// next result. Busy is low again in the cycle that done is high, so a new
// word may be taken at the edge that ends it. An element count of one or
// less is answered in the cycle straight after it is taken and busy does
// not rise for it. Every other word is worked through one shared
// bit-serial divider that yields one quotient bit per cycle. The
// divisions are of 40, 32, 13, 8 (short rows only), 40 and 13 (few-waves
// only) steps. An unroll mismatch is answered after the first division
// and a zero block size after the third. A full answer comes after the
// remaining divisions: for a plain word, with short rows stacked along y,
// with few-waves capping, or in few-waves row mode once the block count
// is halved until it is within 32 waves. Configuration writes are always
// accepted (cfg_ready is tied high) and must only be made while busy is
// low.
module kernel_launch_grid_sizer_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic [klgs_pkg::CountW-1:0]   element_count,
  input  wire logic [klgs_pkg::LastW-1:0]    last_dim_size,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [klgs_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [klgs_pkg::CfgDataW-1:0] cfg_data,
  output      logic                          done,
  output      logic [klgs_pkg::CountW-1:0]   grid_blocks,
  output      logic [klgs_pkg::BxW-1:0]      block_x,
  output      logic [klgs_pkg::ByW-1:0]      block_y,
  output      logic [klgs_pkg::OutcW-1:0]    outcome
);

  localparam int unsigned CW = klgs_pkg::CountW;
  localparam int unsigned XW = klgs_pkg::BxW;
  localparam int unsigned YW = klgs_pkg::ByW;
  localparam int unsigned SW = klgs_pkg::DivSW;

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DN   = 4'd1;  // element count / unroll
  localparam logic [3:0] S_DL   = 4'd2;  // row length / unroll
  localparam logic [3:0] S_DP   = 4'd3;  // block limit / unroll
  localparam logic [3:0] S_DT   = 4'd4;  // y target / row threads
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_LB   = 4'd6;
  localparam logic [3:0] S_DB   = 4'd7;  // block count
  localparam logic [3:0] S_DC   = 4'd8;  // resident threads / block size
  localparam logic [3:0] S_CAP  = 4'd9;
  localparam logic [3:0] S_CMP  = 4'd10;
  localparam logic [3:0] S_HALF = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;

  klgs_pkg::klgs_cfg_t     cfg;
  klgs_pkg::klgs_div_req_t div_req;
  klgs_pkg::klgs_div_rsp_t div_rsp;

  logic [3:0]    state;
  logic [31:0]   last_reg;
  logic [4:0]    u_reg;
  logic [CW-1:0] m;
  logic [XW-1:0] rv;
  logic [XW-1:0] tx;
  logic [YW-1:0] ty;
  logic [SW-1:0] per;
  logic [CW-1:0] bc;
  logic [12:0]   qc;
  logic [23:0]   prod;

  // Combinational helpers.
  logic [XW-1:0] pbl;
  logic [13:0]   rnd;
  logic [XW-1:0] max_lim;
  logic [XW-1:0] max_x;
  logic [XW-1:0] tx_new;
  logic          rv_ok;
  logic [7:0]    cx;
  logic [4:0]    u_in;

  assign cfg_ready = 1'b1;
  assign busy      = state != S_IDLE;

  klgs_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  klgs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign u_in = (cfg.unroll == 5'd0) ? 5'd1 : cfg.unroll;

  // Per-block limit: device limit, else warp width, else one warp of 32.
  always_comb begin
    if (cfg.block_thread_limit != '0) begin
      pbl = cfg.block_thread_limit;
    end else if (cfg.warp_width != '0) begin
      pbl = XW'(cfg.warp_width);
    end else begin
      pbl = klgs_pkg::WARP_DFLT;
    end
  end

  // A row qualifies in row mode when it splits evenly over unroll, is not a
  // whole multiple of 256 and its thread count fits the device limit.
  assign rv_ok = cfg.row_vector_mode && (last_reg != '0) && (div_rsp.rem == '0) &&
                 (last_reg[7:0] != 8'd0) &&
                 (div_rsp.quo <= CW'(cfg.block_thread_limit));

  // Limit divided by unroll, rounded up to a multiple of 32, saturated.
  assign rnd     = {1'b0, div_rsp.quo[XW-1:0]} + 14'd31;
  assign max_lim = rnd[13] ? klgs_pkg::BX_MAX : {rnd[12:5], 5'b0};
  assign max_x   = (rv != '0) ? rv : max_lim;
  assign tx_new  = (m < CW'(max_x)) ? m[XW-1:0] : max_x;
  assign cx      = (tx < XW'(klgs_pkg::Y_TARGET)) ? tx[7:0] : klgs_pkg::Y_TARGET;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      div_req.go <= 1'b0;
    end else begin
      done       <= 1'b0;
      div_req.go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            last_reg <= last_dim_size;
            u_reg    <= u_in;
            if (element_count <= CW'(1)) begin
              done        <= 1'b1;
              grid_blocks <= CW'(1);
              block_x     <= XW'(1);
              block_y     <= YW'(1);
              outcome     <= klgs_pkg::OC_TRIVIAL;
            end else begin
              div_req.go       <= 1'b1;
              div_req.steps    <= 6'd40;
              div_req.dividend <= element_count;
              div_req.divisor  <= SW'(u_in);
              state            <= S_DN;
            end
          end
        end
        S_DN: begin
          if (div_rsp.done) begin
            m <= div_rsp.quo;
            if (div_rsp.rem != '0) begin
              done        <= 1'b1;
              grid_blocks <= '0;
              block_x     <= '0;
              block_y     <= YW'(1);
              outcome     <= klgs_pkg::OC_UNROLL;
              state       <= S_IDLE;
            end else begin
              div_req.go       <= 1'b1;
              div_req.steps    <= 6'd32;
              div_req.dividend <= {last_reg, 8'd0};
              div_req.divisor  <= SW'(u_reg);
              state            <= S_DL;
            end
          end
        end
        S_DL: begin
          if (div_rsp.done) begin
            rv               <= rv_ok ? div_rsp.quo[XW-1:0] : '0;
            div_req.go       <= 1'b1;
            div_req.steps    <= 6'd13;
            div_req.dividend <= {pbl, 27'd0};
            div_req.divisor  <= SW'(u_reg);
            state            <= S_DP;
          end
        end
        S_DP: begin
          if (div_rsp.done) begin
            tx <= tx_new;
            ty <= YW'(1);
            if (tx_new == '0) begin
              done        <= 1'b1;
              grid_blocks <= '0;
              block_x     <= '0;
              block_y     <= YW'(1);
              outcome     <= klgs_pkg::OC_ZERO_BLK;
              state       <= S_IDLE;
            end else if ((rv != '0) && (rv < XW'(klgs_pkg::Y_TARGET)) &&
                         (m > CW'(klgs_pkg::Y_TARGET))) begin
              // Short rows: stack ceil(128 / row threads) rows per block.
              div_req.go       <= 1'b1;
              div_req.steps    <= 6'd8;
              div_req.dividend <= {klgs_pkg::Y_TARGET, 32'd0};
              div_req.divisor  <= SW'(rv);
              state            <= S_DT;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_DT: begin
          if (div_rsp.done) begin
            ty    <= div_rsp.quo[YW-1:0] + YW'(div_rsp.rem != '0);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          per   <= SW'(tx) * SW'(ty);
          state <= S_LB;
        end
        S_LB: begin
          div_req.go       <= 1'b1;
          div_req.steps    <= 6'd40;
          div_req.dividend <= m;
          div_req.divisor  <= per;
          state            <= S_DB;
        end
        S_DB: begin
          if (div_rsp.done) begin
            bc <= div_rsp.quo + CW'(div_rsp.rem != '0);
            if (cfg.few_waves_mode) begin
              // Resident threads per core over the block size: capped x
              // threads in plain mode, full block in row mode.
              div_req.go       <= 1'b1;
              div_req.steps    <= 6'd13;
              div_req.dividend <= {cfg.core_thread_limit, 27'd0};
              div_req.divisor  <= cfg.row_vector_mode ? per : SW'(cx);
              state            <= S_DC;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_DC: begin
          if (div_rsp.done) begin
            qc    <= div_rsp.quo[12:0];
            state <= S_CAP;
          end
        end
        S_CAP: begin
          prod  <= 24'(cfg.core_total) * 24'(qc);
          state <= cfg.row_vector_mode ? S_HALF : S_CMP;
        end
        S_CMP: begin
          if (CW'(prod) < bc) begin
            tx <= XW'(cx);
            bc <= CW'(prod);
          end
          state <= S_FIN;
        end
        S_HALF: begin
          // Halve the block count until it is within 32 waves.
          if (bc > CW'({prod, 5'd0})) begin
            bc <= bc >> 1;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if ((cfg.grid_x_limit != '0) && (bc >= CW'(cfg.grid_x_limit))) begin
            grid_blocks <= '0;
            block_x     <= '0;
            block_y     <= YW'(1);
            outcome     <= klgs_pkg::OC_TOO_MANY;
          end else begin
            grid_blocks <= bc;
            block_x     <= tx;
            block_y     <= ty;
            outcome     <= klgs_pkg::OC_OK;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[verif/tb_kernel_launch_grid_sizer_core.sv]
`timescale 1ns / 1ps

// Self-checking bench for the launch grid sizer. A queue of tensor shapes
// feeds a driver that offers one word at a time on the start/busy
// handshake. A monitor predicts the launch grid of every word taken and
// compares it with the result word that done marks. The device registers
// are retuned between phases, only once the block has gone quiet.
module tb_kernel_launch_grid_sizer_core;

  localparam int unsigned CW = klgs_pkg::CountW;
  localparam int unsigned LW = klgs_pkg::LastW;
  localparam int unsigned XW = klgs_pkg::BxW;
  localparam int unsigned YW = klgs_pkg::ByW;
  localparam int unsigned OW = klgs_pkg::OutcW;
  localparam int unsigned IW = klgs_pkg::CfgIdxW;
  localparam int unsigned DW = klgs_pkg::CfgDataW;

  localparam longint unsigned COUNT_MASK     = 64'hFF_FFFF_FFFF;
  // A row length that is a multiple of this never gets row-vector sizing.
  localparam longint unsigned ROW_SPAN       = 256;
  // The per-block thread limit over unroll is rounded up to this granule.
  localparam longint unsigned THREAD_QUANTUM = 32;
  // In few-waves row mode the block count is halved until it is no more
  // than this many times the resident block count.
  localparam longint unsigned WAVE_MULT      = 32;

  localparam int          PHASES          = 12;
  localparam int          WORDS_PER_PHASE = 136;
  localparam int          PRESSURE_PHASE  = 4;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          TAIL_CYCLES     = 300;
  localparam int unsigned REPORT_LINES    = 40;
  // Sender idling per random phase, in cycles out of a hundred. The
  // receiver cannot hold a result off, so it never stalls.
  localparam int unsigned IDLE_PLAN [3] = '{0, 64, 18};

  typedef struct {
    logic [CW-1:0] count;
    logic [LW-1:0] last;
  } shape_word_t;

  typedef struct {
    logic [CW-1:0] blocks;
    logic [XW-1:0] bx;
    logic [YW-1:0] by;
    logic [OW-1:0] oc;
  } grid_word_t;

  logic          clk           = 1'b0;
  logic          rst           = 1'b1;
  logic          start         = 1'b0;
  logic [CW-1:0] element_count = '0;
  logic [LW-1:0] last_dim_size = '0;
  logic          cfg_valid     = 1'b0;
  logic [IW-1:0] cfg_index     = '0;
  logic [DW-1:0] cfg_data      = '0;
  logic          busy;
  logic          cfg_ready;
  logic          done;
  logic [CW-1:0] grid_blocks;
  logic [XW-1:0] block_x;
  logic [YW-1:0] block_y;
  logic [OW-1:0] outcome;

  // Shapes still to be offered, and the grids owed for shapes taken.
  shape_word_t shapes_waiting [$];
  grid_word_t  grids_due [$];
  shape_word_t on_offer;
  logic        holding         = 1'b0;
  logic        word_taken      = 1'b0;
  int unsigned sender_idle_pct = 0;
  int unsigned mismatch_count  = 0;
  // The bench's own copy of the device registers.
  klgs_pkg::klgs_cfg_t dev_cfg;

  kernel_launch_grid_sizer_core dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .element_count (element_count),
    .last_dim_size (last_dim_size),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .grid_blocks   (grid_blocks),
    .block_x       (block_x),
    .block_y       (block_y),
    .outcome       (outcome)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Works out the launch grid that one shape should get under the given
  // register settings. All the sums are done in 64 bits, which is ample:
  // no product is wider than about 30 bits and the widest sum is the
  // 40-bit count plus one block size.
  function automatic grid_word_t size_grid(klgs_pkg::klgs_cfg_t c, shape_word_t s);
    longint unsigned n, lst, u, m, rv, blim, lim, max_x, tx, ty, per, bc;
    longint unsigned cx, capped, minb, ncores, corelim, glim, ytgt;
    grid_word_t g;
    n       = s.count;
    lst     = s.last;
    u       = c.unroll;
    blim    = c.block_thread_limit;
    ncores  = c.core_total;
    corelim = c.core_thread_limit;
    glim    = c.grid_x_limit;
    ytgt    = klgs_pkg::Y_TARGET;
    g.blocks = '0;
    g.bx     = '0;
    g.by     = YW'(1);
    g.oc     = klgs_pkg::OC_OK;
    // An unroll factor of zero behaves as one.
    if (u == 0) u = 1;
    if (n <= 1) begin
      g.blocks = CW'(1);
      g.bx     = XW'(1);
      g.oc     = klgs_pkg::OC_TRIVIAL;
      return g;
    end
    if (n % u != 0) begin
      g.oc = klgs_pkg::OC_UNROLL;
      return g;
    end
    m = n / u;

    // Row-vector sizing takes the row length as the block width, provided
    // the row is not a whole number of spans and fits the device limit.
    rv = 0;
    if (c.row_vector_mode && lst > 0 && lst % u == 0 && lst % ROW_SPAN != 0 &&
        lst / u <= blim)
      rv = lst / u;

    if (rv > 0) begin
      max_x = rv;
    end else begin
      if (blim != 0) lim = blim;
      else if (c.warp_width != 0) lim = c.warp_width;
      else lim = klgs_pkg::WARP_DFLT;
      max_x = (lim / u + THREAD_QUANTUM - 1) / THREAD_QUANTUM * THREAD_QUANTUM;
      if (max_x > klgs_pkg::BX_MAX) max_x = klgs_pkg::BX_MAX;
    end
    tx = (m < max_x) ? m : max_x;
    if (tx == 0) begin
      g.oc = klgs_pkg::OC_ZERO_BLK;
      return g;
    end

    // Short rows are stacked along y to reach the target block height.
    ty  = (rv > 0 && rv < ytgt && m > ytgt) ? (ytgt + rv - 1) / rv : 1;
    per = tx * ty;
    bc  = (m + per - 1) / per;

    if (c.few_waves_mode && !c.row_vector_mode) begin
      cx     = (tx < ytgt) ? tx : ytgt;
      capped = ncores * (corelim / (cx * ty));
      if (capped < bc) begin
        tx = cx;
        bc = capped;
      end
    end else if (c.few_waves_mode) begin
      minb   = ncores * (corelim / per);
      capped = bc;
      while (capped > WAVE_MULT * minb) capped = capped / 2;
      bc = capped;
    end

    if (glim > 0 && bc >= glim) begin
      g.oc = klgs_pkg::OC_TOO_MANY;
      return g;
    end
    g.blocks = CW'(bc);
    g.bx     = XW'(tx);
    g.by     = YW'(ty);
    return g;
  endfunction

  // Picks a register value: the bounds of its width, a typical setting,
  // something in the usual range, or anything at all. Now and then junk is
  // put above the register's width, which the block must drop.
  function automatic longint unsigned spread(int unsigned width, longint unsigned typical,
                                             int unsigned upper);
    longint unsigned all_ones, v;
    all_ones = (64'd1 << width) - 1;
    case ($urandom_range(5))
      0:       v = 0;
      1:       v = all_ones;
      2, 3:    v = typical;
      4:       v = $urandom_range(upper);
      default: v = {$urandom, $urandom} & all_ones;
    endcase
    if ($urandom_range(3) == 0) v = v | (longint'($urandom) << width);
    return v;
  endfunction

  // Builds one random shape. Most are well formed for the present unroll
  // factor, so that they get past the divisibility check; about half of
  // those are whole rows of a length that suits row-vector sizing.
  function automatic shape_word_t make_shape(klgs_pkg::klgs_cfg_t c);
    longint unsigned u, blim, n, lst, r, rows, raw;
    int unsigned pick;
    shape_word_t s;
    u    = c.unroll;
    blim = c.block_thread_limit;
    if (u == 0) u = 1;
    raw  = {$urandom, $urandom} & COUNT_MASK;
    case ($urandom_range(3))
      0:       lst = 0;
      1:       lst = $urandom;
      2:       lst = $urandom_range(300);
      default: lst = u * $urandom_range(64, 1);
    endcase
    pick = $urandom_range(99);
    if (pick < 5) begin
      n = $urandom_range(1);
    end else if (pick < 15) begin
      // Deliberately not a multiple of the unroll factor, unless that is one.
      n = raw >> $urandom_range(39);
      n = n - n % u;
      if (u > 1) n = n + $urandom_range(u - 1, 1);
      n = n & COUNT_MASK;
    end else if (pick < 50) begin
      r    = $urandom_range(1) ? $urandom_range(127, 1)
                               : $urandom_range((blim > 1) ? blim : 1, 1);
      lst  = r * u;
      if ($urandom_range(7) == 0) lst = ROW_SPAN * $urandom_range(32, 1);
      rows = $urandom_range(1) ? $urandom_range(400, 1) : (raw >> $urandom_range(39, 12)) + 1;
      n    = lst * rows;
      if (n > COUNT_MASK) n = lst * (COUNT_MASK / lst);
    end else if (pick < 70) begin
      n = u * $urandom_range(5000, 2);
    end else if (pick < 90) begin
      n = raw >> $urandom_range(39);
      n = n - n % u;
    end else begin
      n   = raw;
      lst = $urandom;
    end
    s.count = CW'(n);
    s.last  = LW'(lst);
    return s;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LINES) $display("%0t: %s", $time, what);
  endtask

  function automatic void offer(longint unsigned n, longint unsigned l);
    shape_word_t s;
    s.count = CW'(n);
    s.last  = LW'(l);
    shapes_waiting.push_back(s);
  endfunction

  // Writes one device register and keeps the bench's copy in step. The
  // copy only changes at the edge of the handshake, and the block is idle
  // whenever this is called. It returns on a rising edge, so the caller
  // never touches the shape queue at the falling edge that the driver uses.
  task automatic write_reg(logic [IW-1:0] idx, longint unsigned value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= DW'(value);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      klgs_pkg::REG_BLOCK_LIMIT: dev_cfg.block_thread_limit = value[12:0];
      klgs_pkg::REG_WARP_WIDTH:  dev_cfg.warp_width         = value[6:0];
      klgs_pkg::REG_CORE_TOTAL:  dev_cfg.core_total         = value[10:0];
      klgs_pkg::REG_CORE_LIMIT:  dev_cfg.core_thread_limit  = value[12:0];
      klgs_pkg::REG_GRID_LIMIT:  dev_cfg.grid_x_limit       = value[30:0];
      klgs_pkg::REG_UNROLL:      dev_cfg.unroll             = value[4:0];
      klgs_pkg::REG_ROW_MODE:    dev_cfg.row_vector_mode    = value[0];
      klgs_pkg::REG_WAVES_MODE:  dev_cfg.few_waves_mode     = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic retune_random();
    write_reg(klgs_pkg::REG_BLOCK_LIMIT, spread(13, 1024, 4096));
    write_reg(klgs_pkg::REG_WARP_WIDTH,  spread(7, 32, 64));
    write_reg(klgs_pkg::REG_CORE_TOTAL,  spread(11, 80, 1024));
    write_reg(klgs_pkg::REG_CORE_LIMIT,  spread(13, 2048, 4096));
    write_reg(klgs_pkg::REG_GRID_LIMIT,  spread(31, 5000, 1 << 20));
    write_reg(klgs_pkg::REG_UNROLL,      spread(5, 2, 16));
    write_reg(klgs_pkg::REG_ROW_MODE,    spread(1, 1, 1));
    write_reg(klgs_pkg::REG_WAVES_MODE,  spread(1, 1, 1));
  endtask

  // Waits until every shape has been offered and taken and every grid owed
  // has come back. Polling at the falling edge is safe: a word can only be
  // dropped by the driver once its grid is already owed. A settling wait
  // then follows before anything else is done.
  task automatic wait_drained();
    do @(negedge clk);
    while (shapes_waiting.size() != 0 || holding || grids_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver. A word stays on offer, with start high, until the monitor has
  // seen it taken; only then may the next shape be offered, after a random
  // idle spell where the phase asks for one. While nothing is on offer the
  // shape ports carry junk, which the block must ignore.
  always @(negedge clk) begin : feed
    if (rst) begin
      holding = 1'b0;
      start <= 1'b0;
    end else begin
      if (holding && word_taken) holding = 1'b0;
      if (!holding && shapes_waiting.size() != 0 &&
          $urandom_range(99) >= sender_idle_pct) begin
        on_offer = shapes_waiting.pop_front();
        holding  = 1'b1;
      end
      start <= holding;
      if (holding) begin
        element_count <= on_offer.count;
        last_dim_size <= on_offer.last;
      end else begin
        element_count <= CW'({$urandom, $urandom});
        last_dim_size <= $urandom;
      end
    end
  end

  // Monitor. The result word is checked before any new word is booked, so
  // that a result arriving with nothing owed is never matched against a
  // grid booked in the same cycle.
  always @(posedge clk) begin : watch
    grid_word_t due;
    if (rst) begin
      word_taken = 1'b0;
    end else begin
      if (done) begin
        if (grids_due.size() == 0) begin
          report_mismatch($sformatf("result word with nothing owed: blocks %0d", grid_blocks));
        end else begin
          due = grids_due.pop_front();
          if (grid_blocks !== due.blocks)
            report_mismatch($sformatf("grid_blocks %0d, wanted %0d", grid_blocks, due.blocks));
          if (block_x !== due.bx)
            report_mismatch($sformatf("block_x %0d, wanted %0d", block_x, due.bx));
          if (block_y !== due.by)
            report_mismatch($sformatf("block_y %0d, wanted %0d", block_y, due.by));
          if (outcome !== due.oc)
            report_mismatch($sformatf("outcome %0d, wanted %0d", outcome, due.oc));
        end
      end
      word_taken = start && !busy;
      if (word_taken)
        grids_due.push_back(size_grid(dev_cfg, '{count: element_count, last: last_dim_size}));
    end
  end

  initial begin : stimulus
    dev_cfg = '{block_thread_limit: 13'd1024, warp_width: 7'd32, core_total: 11'd80,
                core_thread_limit: 13'd2048, grid_x_limit: 31'h7FFF_FFFF, unroll: 5'd1,
                row_vector_mode: 1'b0, few_waves_mode: 1'b0};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed shapes, first under the reset settings: trivial counts,
    // the smallest real count, the widest count and row, and a medium count.
    sender_idle_pct = 0;
    offer(0, 0);
    offer(1, 7);
    offer(2, 0);
    offer(COUNT_MASK, 32'hFFFF_FFFF);
    offer(1024000, 5);
    wait_drained();

    // Row-vector mode with an unroll of three: a count that does not
    // divide, a short row stacked along y, a row of whole spans, a zero
    // last dimension and a medium row.
    write_reg(klgs_pkg::REG_UNROLL, 3);
    write_reg(klgs_pkg::REG_ROW_MODE, 1);
    offer(10, 5);
    offer(96000, 96);
    offer(15360, 512);
    offer(150, 0);
    offer(900, 300);
    wait_drained();

    // Unknown device limit with no warp width and a zero unroll factor:
    // the fallback of 32 threads overflows the block count limit.
    write_reg(klgs_pkg::REG_BLOCK_LIMIT, 0);
    write_reg(klgs_pkg::REG_WARP_WIDTH, 0);
    write_reg(klgs_pkg::REG_UNROLL, 0);
    write_reg(klgs_pkg::REG_ROW_MODE, 0);
    write_reg(klgs_pkg::REG_GRID_LIMIT, 31'h7FFF_FFFF);
    offer(COUNT_MASK, 0);
    offer(64, 1);
    wait_drained();

    // A one-thread fallback divided by sixteen leaves no threads at all.
    write_reg(klgs_pkg::REG_WARP_WIDTH, 1);
    write_reg(klgs_pkg::REG_UNROLL, 16);
    offer(32, 0);
    wait_drained();

    // The widest device limit saturates the rounded block width; few-waves
    // mode caps the count, with the limit check switched off.
    write_reg(klgs_pkg::REG_BLOCK_LIMIT, 8191);
    write_reg(klgs_pkg::REG_WARP_WIDTH, 127);
    write_reg(klgs_pkg::REG_UNROLL, 1);
    write_reg(klgs_pkg::REG_WAVES_MODE, 1);
    write_reg(klgs_pkg::REG_CORE_TOTAL, 2047);
    write_reg(klgs_pkg::REG_CORE_LIMIT, 8191);
    write_reg(klgs_pkg::REG_GRID_LIMIT, 0);
    offer(COUNT_MASK, 0);
    offer(24573, 9);
    wait_drained();

    // No cores at all caps the block count to nothing.
    write_reg(klgs_pkg::REG_CORE_TOTAL, 0);
    offer(100000, 0);
    wait_drained();

    // Few-waves row mode, which halves the block count repeatedly, and
    // then a block count limit that a plain shape exceeds.
    write_reg(klgs_pkg::REG_BLOCK_LIMIT, 1024);
    write_reg(klgs_pkg::REG_ROW_MODE, 1);
    write_reg(klgs_pkg::REG_CORE_TOTAL, 80);
    write_reg(klgs_pkg::REG_CORE_LIMIT, 2048);
    offer(1000000000, 100);
    offer(1000000000, 1000);
    offer(320000, 64);
    wait_drained();
    write_reg(klgs_pkg::REG_GRID_LIMIT, 50);
    offer(102400, 0);
    wait_drained();

    // Random phases, each under freshly drawn registers. In one of them the
    // sender stops halfway until every grid owed has come back.
    for (int p = 0; p < PHASES; p++) begin
      retune_random();
      sender_idle_pct = IDLE_PLAN[p % 3];
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        if (p == PRESSURE_PHASE && k == WORDS_PER_PHASE / 2) wait_drained();
        shapes_waiting.push_back(make_shape(dev_cfg));
      end
      wait_drained();
    end

    // Leave room for any stray result word before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("kernel_launch_grid_sizer_core: match");
    end else begin
      $display("kernel_launch_grid_sizer_core: mismatch");
    end
    $finish;
  end

  // Ends the run as a mismatch if the stimulus never finishes.
  initial begin : watchdog
    #25_000_000;
    $display("kernel_launch_grid_sizer_core: mismatch");
    $finish;
  end

endmodule
